@@ hdl/rcbd_pkg.sv @@
package rcbd_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned UW       = 31;
  localparam int unsigned BcW      = 34;
  localparam int unsigned QW       = 31;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned MidDepth = 4;
  localparam int unsigned MidPtrW  = 2;

  localparam logic [UW-1:0]  URstY  = UW'(32'd536870912);
  localparam logic [BcW-1:0] BcRstY = BcW'(-34'sd32768);

  typedef enum logic [2:0] {
    REG_CENTRE_X      = 3'd0,
    REG_CENTRE_Y      = 3'd1,
    REG_CENTRE_Z      = 3'd2,
    REG_AXIS_X        = 3'd3,
    REG_AXIS_Y        = 3'd4,
    REG_AXIS_Z        = 3'd5,
    REG_CONE_HEIGHT   = 3'd6,
    REG_BASE_DIAMETER = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_BASE
  } setup_state_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        max_distance;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_distance;
  } result_t;

  typedef struct packed {
    logic [2:0][UW-1:0]  u;
    logic [2:0][BcW-1:0] bc;
    logic [30:0]         base_diameter;
  } geom_t;

  typedef struct packed {
    logic                miss;
    logic [63:0]         num;
    logic [63:0]         den;
    logic [2:0][31:0]    dir;
    logic [2:0][BcW-1:0] tc;
    logic [30:0]         max_distance;
  } cls_t;

endpackage

@@ hdl/ray_cone_base_disk_intersect_unit.sv @@
// Ray test against the base disk of a configured cone, Q16.16 fixed point.
// Input channel: drive ray_i and raise push; a beat is taken on a rising
// edge with push high and full low. Result channel: while empty is low the
// oldest result sits on result_o; pop with empty low takes the beat.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// write only while no ray is in flight. Each write starts a setup pass
// (axis length by a one-bit-per-cycle square root, three divisions
// for the unit axis, base centre) during which full stays high.
// Throughput: one ray per cycle while full is low. A ray passes the front
// stages, the middle queue, the 31-stage quotient pipeline and the radius
// test stages behind it before empty falls.
// A three-stage front computes the two dot products and flags early misses
// into a four-beat queue; the back divides and checks the radius, and
// stalls as a whole only when its two-beat result queue is full, which in
// turn fills the middle queue and raises full.
// Reset: registers take their reset values (unit axis along y, height and
// diameter 1.0); the derived geometry loads at once, no setup pass needed.
module ray_cone_base_disk_intersect_unit
  import rcbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  ray_t        ray_i,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  geom_t geom;
  logic  busy, front_en, take_in, cls_valid, mid_full, mid_empty, mid_rd;
  cls_t  cls, mid_data;

  rcbd_setup u_setup (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .geom_o (geom),
    .busy_o (busy)
  );

  assign front_en = !mid_full;
  assign full     = busy || mid_full;
  assign take_in  = push && !full;

  rcbd_front u_front (
    .clk_i,
    .rst_ni,
    .en_i        (front_en),
    .take_i      (take_in),
    .ray_i,
    .geom_i      (geom),
    .cls_valid_o (cls_valid),
    .cls_o       (cls)
  );

  rcbd_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (cls_valid && front_en),
    .data_i  (cls),
    .rd_i    (mid_rd),
    .data_o  (mid_data),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  rcbd_back u_back (
    .clk_i,
    .rst_ni,
    .cls_valid_i (!mid_empty),
    .cls_i       (mid_data),
    .diam_i      (geom.base_diameter),
    .pop_i       (pop),
    .take_o      (mid_rd),
    .empty_o     (empty),
    .result_o
  );

endmodule

@@ hdl/rcbd_setup.sv @@
module rcbd_setup
  import rcbd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  cfg_idx_e      cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  output geom_t         geom_o,
  output logic          busy_o
);

  setup_state_e        state_q, state_d;
  logic [2:0][31:0]    centre_q, centre_d;
  logic [2:0][31:0]    axis_q, axis_d;
  logic [30:0]         height_q, height_d;
  logic [30:0]         diam_q, diam_d;
  logic [2:0][UW-1:0]  u_q, u_d;
  logic [2:0][BcW-1:0] bc_q, bc_d;
  logic [1:0]          idx_q, idx_d;
  logic [4:0]          step_q, step_d;
  logic [63:0]         acc_q, acc_d;
  logic [63:0]         rem_q, rem_d;
  logic [63:0]         res_q, res_d;
  logic [61:0]         num_q, num_d;
  logic [31:0]         dr_q, dr_d;
  logic [QW-1:0]       quo_q, quo_d;
  logic [61:0]         prod_q, prod_d;

  logic signed [31:0]  a_cur;
  logic signed [63:0]  sq;
  logic [63:0]         sbit, ssum;
  logic [31:0]         len, amag;
  logic [32:0]         rs;
  logic                ge;
  logic [QW-1:0]       qfin;
  logic [UW-1:0]       umag;
  logic [62:0]         ofs;
  logic [32:0]         offm;
  logic signed [BcW-1:0] off;

  always_comb begin
    state_d  = state_q;
    centre_d = centre_q;
    axis_d   = axis_q;
    height_d = height_q;
    diam_d   = diam_q;
    u_d      = u_q;
    bc_d     = bc_q;
    idx_d    = idx_q;
    step_d   = step_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    res_d    = res_q;
    num_d    = num_q;
    dr_d     = dr_q;
    quo_d    = quo_q;
    prod_d   = prod_q;

    a_cur = $signed(axis_q[idx_q]);
    sq    = a_cur * a_cur;
    sbit  = 64'(1) << {step_q, 1'b0};
    ssum  = res_q + sbit;
    len   = res_q[31:0];
    amag  = a_cur[31] ? 32'(-a_cur) : 32'(a_cur);
    rs    = {dr_q, num_q[step_q]};
    ge    = rs >= {1'b0, len};
    qfin  = {quo_q[QW-2:0], ge};
    umag  = u_q[idx_q][UW-1] ? UW'(-u_q[idx_q]) : u_q[idx_q];
    ofs   = 63'(prod_q) + 63'(64'd1 << 29);
    offm  = ofs[62:30];
    off   = u_q[idx_q][UW-1] ? -$signed({1'b0, offm}) : $signed({1'b0, offm});

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_SQUARE: begin
        acc_d = acc_q + 64'(sq);
        if (idx_q == 2'd2) begin
          state_d = ST_SQRT;
          rem_d   = acc_q + 64'(sq);
          res_d   = '0;
          step_d  = 5'd31;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      ST_SQRT: begin
        if (rem_q >= ssum) begin
          rem_d = rem_q - ssum;
          res_d = (res_q >> 1) + sbit;
        end else begin
          res_d = res_q >> 1;
        end
        if (step_q == '0) begin
          state_d = ST_LOAD;
          idx_d   = '0;
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      ST_LOAD: begin
        num_d   = 62'({amag, 29'b0}) + 62'(len[31:1]);
        dr_d    = 32'(num_d >> 31);
        quo_d   = '0;
        step_d  = 5'(QW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dr_d  = ge ? 32'(rs - {1'b0, len}) : rs[31:0];
        quo_d = qfin;
        if (step_q == '0) begin
          if (len == '0) begin
            u_d[idx_q] = '0;
          end else begin
            u_d[idx_q] = a_cur[31] ? UW'(-qfin) : UW'(qfin);
          end
          state_d = ST_MUL;
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      ST_MUL: begin
        prod_d  = height_q * umag;
        state_d = ST_BASE;
      end
      ST_BASE: begin
        bc_d[idx_q] = BcW'($signed(centre_q[idx_q]) - off);
        if (idx_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTRE_X:      centre_d[0] = cfg_data_i;
        REG_CENTRE_Y:      centre_d[1] = cfg_data_i;
        REG_CENTRE_Z:      centre_d[2] = cfg_data_i;
        REG_AXIS_X:        axis_d[0]   = cfg_data_i;
        REG_AXIS_Y:        axis_d[1]   = cfg_data_i;
        REG_AXIS_Z:        axis_d[2]   = cfg_data_i;
        REG_CONE_HEIGHT:   height_d    = cfg_data_i[30:0];
        REG_BASE_DIAMETER: diam_d      = cfg_data_i[30:0];
        default:           diam_d      = diam_q;
      endcase
      state_d = ST_SQUARE;
      idx_d   = '0;
      acc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      centre_q <= '0;
      axis_q   <= {32'd0, 32'd65536, 32'd0};
      height_q <= 31'd65536;
      diam_q   <= 31'd65536;
      u_q      <= {UW'(0), URstY, UW'(0)};
      bc_q     <= {BcW'(0), BcRstY, BcW'(0)};
      idx_q    <= '0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      centre_q <= centre_d;
      axis_q   <= axis_d;
      height_q <= height_d;
      diam_q   <= diam_d;
      u_q      <= u_d;
      bc_q     <= bc_d;
      idx_q    <= idx_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    num_q  <= num_d;
    dr_q   <= dr_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
  end

  assign geom_o.u             = u_q;
  assign geom_o.bc            = bc_q;
  assign geom_o.base_diameter = diam_q;
  assign busy_o               = state_q != ST_IDLE;

endmodule

@@ hdl/rcbd_front.sv @@
module rcbd_front
  import rcbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  take_i,
  input  ray_t  ray_i,
  input  geom_t geom_i,
  output logic  cls_valid_o,
  output cls_t  cls_o
);

  logic                 v0_q, v1_q, v2_q;
  logic [2:0][31:0]     dir0_q, dir1_q, dir2_q;
  logic [2:0][BcW-1:0]  tc0_q, tc1_q, tc2_q;
  logic [30:0]          max0_q, max1_q, max2_q;
  logic [2:0][63:0]     pd_q, pt_q;
  logic signed [63:0]   d0_q, d1_q;

  logic [2:0][31:0]     org, dir;
  logic [2:0][BcW-1:0]  tc;
  logic [2:0][63:0]     pd, pt;
  logic signed [64:0]   mt;
  logic signed [63:0]   sd0, sd1;

  always_comb begin
    org = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
    dir = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};
    for (int i = 0; i < 3; i++) begin
      tc[i] = BcW'($signed(geom_i.bc[i]) - $signed(org[i]));
    end
    for (int i = 0; i < 3; i++) begin
      pd[i] = 64'($signed(geom_i.u[i]) * $signed(dir0_q[i]));
      mt    = $signed(geom_i.u[i]) * $signed(tc0_q[i]);
      pt[i] = mt[63:0];
    end
    sd0 = $signed(pd_q[0]) + $signed(pd_q[1]) + $signed(pd_q[2]);
    sd1 = $signed(pt_q[0]) + $signed(pt_q[1]) + $signed(pt_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= take_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir0_q <= dir;
      tc0_q  <= tc;
      max0_q <= ray_i.max_distance;
      dir1_q <= dir0_q;
      tc1_q  <= tc0_q;
      max1_q <= max0_q;
      pd_q   <= pd;
      pt_q   <= pt;
      dir2_q <= dir1_q;
      tc2_q  <= tc1_q;
      max2_q <= max1_q;
      d0_q   <= sd0;
      d1_q   <= sd1;
    end
  end

  assign cls_valid_o        = v2_q;
  assign cls_o.miss         = (d0_q == '0) || (d1_q == '0) || (d0_q[63] != d1_q[63]);
  assign cls_o.num          = d1_q[63] ? 64'(-d1_q) : 64'(d1_q);
  assign cls_o.den          = d0_q[63] ? 64'(-d0_q) : 64'(d0_q);
  assign cls_o.dir          = dir2_q;
  assign cls_o.tc           = tc2_q;
  assign cls_o.max_distance = max2_q;

endmodule

@@ hdl/rcbd_queue.sv @@
module rcbd_queue
  import rcbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cls_t data_i,
  input  logic rd_i,
  output cls_t data_o,
  output logic empty_o,
  output logic full_o
);

  cls_t               mem_q [MidDepth];
  logic [MidPtrW-1:0] wp_q, rp_q;
  logic [MidPtrW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (MidPtrW+1)'(wr_i) - (MidPtrW+1)'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= data_i;
  end

  assign data_o  = mem_q[rp_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (MidPtrW+1)'(MidDepth);

endmodule

@@ hdl/rcbd_back.sv @@
module rcbd_back
  import rcbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cls_valid_i,
  input  cls_t        cls_i,
  input  logic [30:0] diam_i,
  input  logic        pop_i,
  output logic        take_o,
  output logic        empty_o,
  output result_t     result_o
);

  logic                              en, oq_full, oq_wr, oq_rd;
  logic [DivSteps:0]                 dv_q, dm_q;
  logic [DivSteps:0][63:0]           dr_q, dd_q;
  logic [DivSteps:0][QW-1:0]         dq_q, dn_q;
  logic [DivSteps:0][2:0][31:0]      ddir_q;
  logic [DivSteps:0][2:0][BcW-1:0]   dtc_q;
  logic [DivSteps:0][30:0]           dmax_q;

  logic [DivSteps-1:0][63:0]         nr;
  logic [DivSteps-1:0][QW-1:0]       nq;
  logic [64:0]                       rs;
  logic                              ge;
  logic [48:0]                       nhi;
  logic                              ovf;

  logic                              e1_v_q, e2_v_q, e3_v_q;
  logic                              e1_miss_q, e2_miss_q, e3_miss_q;
  logic [QW-1:0]                     e1_t_q, e2_t_q, e3_t_q;
  logic [2:0][63:0]                  e1_pt_q;
  logic [2:0][BcW-1:0]               e1_tc_q;
  logic [2:0][30:0]                  e2_w_q;
  logic [2:0][61:0]                  e3_sq_q;
  logic [61:0]                       e3_dsq_q;

  logic [QW-1:0]                     tq;
  logic                              e1_miss;
  logic [2:0][63:0]                  pt;
  logic [63:0]                       pm;
  logic [47:0]                       rq;
  logic signed [49:0]                rv, vv;
  logic [50:0]                       w;
  logic                              far;
  logic [2:0][30:0]                  wl;
  logic [63:0]                       wsum;
  logic                              fin_miss;

  result_t                           oq_mem_q [2];
  logic                              oq_wp_q, oq_rp_q;
  logic [1:0]                        oq_cnt_q;
  result_t                           oq_data;

  assign en     = !oq_full;
  assign take_o = en && cls_valid_i;

  always_comb begin
    nhi = cls_i.num[63:15];
    ovf = {15'b0, nhi} >= cls_i.den;
    for (int s = 0; s < DivSteps; s++) begin
      rs    = {dr_q[s], dn_q[s][QW-1-s]};
      ge    = rs >= {1'b0, dd_q[s]};
      nr[s] = ge ? 64'(rs - {1'b0, dd_q[s]}) : rs[63:0];
      nq[s] = {dq_q[s][QW-2:0], ge};
    end
  end

  always_comb begin
    tq      = dq_q[DivSteps];
    e1_miss = dm_q[DivSteps] || (tq == '0) || (tq > dmax_q[DivSteps]);
    for (int i = 0; i < 3; i++) begin
      pt[i] = 64'($signed({1'b0, tq}) * $signed(ddir_q[DivSteps][i]));
    end
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pm    = e1_pt_q[i][63] ? 64'(-e1_pt_q[i]) : e1_pt_q[i];
      rq    = 48'((65'(pm) + 65'(32768)) >> 16);
      rv    = e1_pt_q[i][63] ? -$signed({2'b0, rq}) : $signed({2'b0, rq});
      vv    = rv - $signed(e1_tc_q[i]);
      w     = vv[49] ? {50'(-vv), 1'b0} : {50'(vv), 1'b0};
      far   = far || (w > {20'b0, diam_i});
      wl[i] = w[30:0];
    end
    wsum     = 64'(e3_sq_q[0]) + 64'(e3_sq_q[1]) + 64'(e3_sq_q[2]);
    fin_miss = e3_miss_q || (wsum > 64'(e3_dsq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= '0;
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
    end else if (en) begin
      dv_q   <= {dv_q[DivSteps-1:0], take_o};
      e1_v_q <= dv_q[DivSteps];
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dr_q[0]   <= 64'(nhi);
      dd_q[0]   <= cls_i.den;
      dq_q[0]   <= '0;
      dn_q[0]   <= {cls_i.num[14:0], 16'b0};
      dm_q[0]   <= cls_i.miss || ovf;
      ddir_q[0] <= cls_i.dir;
      dtc_q[0]  <= cls_i.tc;
      dmax_q[0] <= cls_i.max_distance;
      for (int s = 0; s < DivSteps; s++) begin
        dr_q[s+1]   <= nr[s];
        dd_q[s+1]   <= dd_q[s];
        dq_q[s+1]   <= nq[s];
        dn_q[s+1]   <= dn_q[s];
        dm_q[s+1]   <= dm_q[s];
        ddir_q[s+1] <= ddir_q[s];
        dtc_q[s+1]  <= dtc_q[s];
        dmax_q[s+1] <= dmax_q[s];
      end
      e1_t_q    <= tq;
      e1_miss_q <= e1_miss;
      e1_pt_q   <= pt;
      e1_tc_q   <= dtc_q[DivSteps];
      e2_t_q    <= e1_t_q;
      e2_miss_q <= e1_miss_q || far;
      e2_w_q    <= wl;
      e3_t_q    <= e2_t_q;
      e3_miss_q <= e2_miss_q;
      for (int i = 0; i < 3; i++) begin
        e3_sq_q[i] <= e2_w_q[i] * e2_w_q[i];
      end
      e3_dsq_q  <= diam_i * diam_i;
    end
  end

  assign oq_wr                 = en && e3_v_q;
  assign oq_rd                 = pop_i && !empty_o;
  assign oq_data.hit           = !fin_miss;
  assign oq_data.hit_distance  = fin_miss ? '0 : e3_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_wr) oq_wp_q <= !oq_wp_q;
      if (oq_rd) oq_rp_q <= !oq_rp_q;
      oq_cnt_q <= oq_cnt_q + 2'(oq_wr) - 2'(oq_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) oq_mem_q[oq_wp_q] <= oq_data;
  end

  assign oq_full  = oq_cnt_q == 2'd2;
  assign empty_o  = oq_cnt_q == '0;
  assign result_o = oq_mem_q[oq_rp_q];

endmodule

@@ hdl/rcbd_checker.sv @@
module rcbd_checker
  import rcbd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input result_t     result_o,
  input logic        cfg_we_i
);

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !result_o.hit |-> result_o.hit_distance == '0)
    else $error("miss with nonzero distance");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.hit |-> result_o.hit_distance != '0)
    else $error("hit below epsilon");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed");

  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> full)
    else $error("input open during setup");

endmodule

bind ray_cone_base_disk_intersect_unit rcbd_checker u_rcbd_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rcbd_pkg::*;

  localparam int unsigned HoldCycles = 2000;
  localparam int unsigned DrainCycles = 60;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  ray_t ray_i = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result_o;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = REG_CENTRE_X;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic signed [31:0] cone_centre [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic signed [31:0] cone_axis [3] = '{32'sd0, 32'sd65536, 32'sd0};
  logic [30:0] cone_height = 31'd65536;
  logic [30:0] base_diam = 31'd65536;

  ray_t ray_q[$];
  result_t hit_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_load = 1'b0;
  int unsigned hold_left = 0;
  int unsigned err_cnt = 0;
  longint unsigned cyc = 0;

  ray_cone_base_disk_intersect_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .ray_i      (ray_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint n);
    return (n < 0) ? 64'd0 - longint'(n) : longint'(n);
  endfunction

  function automatic longint round_div(longint n, longint unsigned den);
    longint unsigned q;
    q = (mag(n) + den / 2) / den;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned rem, res, b;
    rem = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_axis(int k);
    longint unsigned sum, len;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += longint'(cone_axis[i]) * longint'(cone_axis[i]);
    len = isqrt(sum);
    if (len == 0) return 0;
    return round_div(longint'(cone_axis[k]) * (64'sd1 <<< 29), len);
  endfunction

  function automatic longint base_centre(int k);
    return longint'(cone_centre[k]) -
           round_div(longint'({1'b0, cone_height}) * unit_axis(k), 64'd1 << 30);
  endfunction

  function automatic result_t predict_disk_hit(ray_t r);
    longint o[3], dr[3], tc[3], u, d0, d1, v;
    longint unsigned n, d, rem, t, w, w2, dm;
    result_t res;
    o = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
    dr = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
    res = '0;
    d0 = 0;
    d1 = 0;
    w2 = 0;
    dm = 64'(base_diam);
    for (int i = 0; i < 3; i++) begin
      u = unit_axis(i);
      tc[i] = base_centre(i) - o[i];
      d0 += u * dr[i];
      d1 += u * tc[i];
    end
    if (d0 == 0 || d1 == 0) return res;
    if ((d0 < 0) != (d1 < 0)) return res;
    n = mag(d1);
    d = mag(d0);
    t = n / d;
    if (t >= (64'd1 << 15)) return res;
    rem = n % d;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      t = t << 1;
      if (rem >= d) begin
        rem = rem - d;
        t = t | 1;
      end
    end
    if (t < 1 || t > longint'(r.max_distance)) return res;
    for (int i = 0; i < 3; i++) begin
      v = round_div(longint'(t) * dr[i], 65536) - tc[i];
      w = 2 * mag(v);
      if (w > dm) return res;
      w2 += w * w;
    end
    if (w2 > dm * dm) return res;
    res.hit = 1'b1;
    res.hit_distance = t[30:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_word(int unsigned span);
    if ($urandom_range(1) == 0) return $urandom;
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.origin_x = rand_word(1 << 20);
    r.origin_y = rand_word(1 << 20);
    r.origin_z = rand_word(1 << 20);
    r.dir_x = rand_word(1 << 17);
    r.dir_y = rand_word(1 << 17);
    r.dir_z = rand_word(1 << 17);
    r.max_distance = 31'(($urandom_range(1) == 0) ? $urandom : $urandom_range(1 << 20));
    return r;
  endfunction

  function automatic ray_t aimed_ray();
    ray_t r;
    longint p[3], o[3], dv[3], tq, span, md;
    tq = longint'($urandom_range(1 << 19, 1 << 13));
    span = longint'(base_diam) / 4;
    if (span > (1 << 28)) span = 1 << 28;
    for (int i = 0; i < 3; i++) begin
      dv[i] = longint'($urandom_range(1 << 18)) - (1 << 17);
      p[i] = base_centre(i) + longint'($urandom_range(32'(span * 2))) - span;
      o[i] = p[i] - ((tq * dv[i]) >>> 16);
    end
    r.origin_x = o[0][31:0];
    r.origin_y = o[1][31:0];
    r.origin_z = o[2][31:0];
    r.dir_x = dv[0][31:0];
    r.dir_y = dv[1][31:0];
    r.dir_z = dv[2][31:0];
    if ($urandom_range(3) == 0) begin
      md = tq + longint'($urandom_range(4096)) - 2048;
      r.max_distance = (md < 0) ? 31'd0 : md[30:0];
    end else begin
      r.max_distance = 31'h7fffffff - 31'($urandom_range(1 << 20));
    end
    return r;
  endfunction

  function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz, longint md);
    ray_t r;
    r.origin_x = ox[31:0];
    r.origin_y = oy[31:0];
    r.origin_z = oz[31:0];
    r.dir_x = dx[31:0];
    r.dir_y = dy[31:0];
    r.dir_z = dz[31:0];
    r.max_distance = md[30:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    if (!rst_ni) begin
      push <= 1'b0;
      ray_i <= '0;
    end else begin
      if (push && !full) begin
        hit_q.push_back(predict_disk_hit(ray_i));
        void'(ray_q.pop_front());
      end
      go = (ray_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      push <= go;
      if (go) ray_i <= ray_q[0];
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_load) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (hit_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result beat: %p", result_o);
        end else begin
          want = hit_q.pop_front();
          if (result_o.hit !== want.hit || result_o.hit_distance !== want.hit_distance) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                       want.hit, want.hit_distance, result_o.hit, result_o.hit_distance);
          end
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (ray_q.size() != 0 || hit_q.size() != 0 || push) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cone(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                            logic [30:0] h, logic [30:0] dm);
    logic [31:0] vals [8];
    vals = '{cx, cy, cz, ax, ay, az, {1'b0, h}, {1'b0, dm}};
    for (int k = 0; k < 8; k++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(k);
      cfg_data_i <= vals[k];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      cone_centre[i] = vals[i];
      cone_axis[i] = vals[3 + i];
    end
    cone_height = h;
    base_diam = dm;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic queue_rays(int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      ray_q.push_back(($urandom_range(99) < 65) ? aimed_ray() : noise_ray());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    ray_q.push_back(make_ray(0, 0, 0, 0, 0, 0, 0));
    ray_q.push_back(make_ray(-1, -1, -1, -1, -1, -1, 31'h7fffffff));
    ray_q.push_back(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
    ray_q.push_back(make_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                             -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0));
    ray_q.push_back(make_ray(0, 131072, 0, 0, -65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, 131072, 0, 0, -65536, 0, 0));
    ray_q.push_back(make_ray(0, 131072, 0, 0, 65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, 131072, 0, 65536, 0, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(32768, 65536, 0, 0, -65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(32769, 65536, 0, 0, -65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, 65536, 32768, 0, -65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, 131072, 0, 0, -65536, 0, 163839));
    ray_q.push_back(make_ray(0, 131072, 0, 0, -65536, 0, 163840));
    ray_q.push_back(make_ray(0, -32768, 0, 0, -65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, -32767, 0, 0, -65536, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, 131072, 0, 0, -1, 0, 31'h7fffffff));
    ray_q.push_back(make_ray(0, 131072, 0, 1, -65536, 1, 31'h7fffffff));
    ray_q.push_back(make_ray(-32768, 32768, 0, 65536, -65536, 0, 31'h7fffffff));
    queue_rays(220);
    wait_drained();

    write_cone($urandom_range(1 << 23) - (1 << 22), $urandom_range(1 << 23) - (1 << 22),
               $urandom_range(1 << 23) - (1 << 22), $urandom_range(1 << 19) - (1 << 18),
               $urandom_range(1 << 19) - (1 << 18), $urandom_range(1 << 19) - (1 << 18),
               31'($urandom_range(1 << 20, 1 << 16)), 31'($urandom_range(1 << 21, 1 << 18)));
    set_idling(75, 0);
    queue_rays(130);
    wait_drained();
    queue_rays(130);
    wait_drained();

    write_cone(32'h7fffffff, 32'h80000000, 32'h12345678, 32'h80000000, 32'h7fffffff, 0,
               31'h7fffffff, 31'h7fffffff);
    set_idling(0, 75);
    queue_rays(200);
    wait_drained();

    write_cone(0, 0, 0, 0, 0, 0, 0, 0);
    set_idling(23, 23);
    queue_rays(60);
    wait_drained();

    write_cone($urandom_range(1 << 21) - (1 << 20), $urandom_range(1 << 21) - (1 << 20),
               $urandom_range(1 << 21) - (1 << 20), $urandom_range(1 << 17) - (1 << 16),
               $urandom_range(1 << 17) - (1 << 16), $urandom_range(1 << 17) - (1 << 16),
               31'($urandom_range(1 << 18)), 31'h7fffffff);
    set_idling(23, 23);
    queue_rays(250);
    wait_drained();

    write_cone($urandom_range(1 << 21) - (1 << 20), $urandom_range(1 << 21) - (1 << 20),
               $urandom_range(1 << 21) - (1 << 20), $urandom_range(1 << 17) - (1 << 16),
               $urandom_range(1 << 17) - (1 << 16), $urandom_range(1 << 17) - (1 << 16),
               31'($urandom_range(1 << 20, 1 << 16)), 31'($urandom_range(1 << 21, 1 << 17)));
    set_idling(0, 0);
    @(posedge clk_i);
    hold_load <= 1'b1;
    @(posedge clk_i);
    hold_load <= 1'b0;
    queue_rays(300);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rcbd_pkg.sv
hdl/rcbd_setup.sv
hdl/rcbd_front.sv
hdl/rcbd_queue.sv
hdl/rcbd_back.sv
hdl/ray_cone_base_disk_intersect_unit.sv
hdl/rcbd_checker.sv
dv/testbench.sv
